[src/pbnp_pkg.sv]
// Shared types, constants and the arctangent table for the polar bin nearest point block.
// Used by every module of the block but pbnp_ram; depends on nothing else.
package pbnp_pkg;

	localparam int NUM_RINGS_DEF    = 16;
	localparam int NUM_BINS_DEF     = 90;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam int COORD_W    = 19;
	localparam int DELTA_W    = 20;
	localparam int ANGLE_W    = 25;
	localparam int ATAN_W     = 21;
	localparam int TVAL_W     = 23;
	localparam int SQ_W       = 40;
	localparam int DIST_W     = 41;
	localparam int OP_W       = 2;
	localparam int RING_W     = 4;
	localparam int BIN_W      = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 72;
	localparam int ENTRY_W    = 3 * COORD_W;

	// Angles are in 1/32768 degree: 90 degrees and 180 degrees.
	localparam int HALF_SPAN  = 2949120;
	localparam int FULL_SPAN  = 5898240;
	// FULL_SPAN = 45 * 2^17, so the bin divide is a shift and a divide by 45.
	localparam int SPAN_SHIFT  = 17;
	localparam int SPAN_DIV    = 45;
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP       = ((1 << RECIP_SHIFT) + SPAN_DIV - 1) / SPAN_DIV;
	localparam int RECIP_W     = 19;
	localparam int QUO_W       = 16;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_READ   = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DECODE, ST_CORDIC, ST_SPAN, ST_SCALE, ST_RECIP, ST_INDEX,
		ST_RD_REQ, ST_RD_WAIT, ST_SQ_NX, ST_SQ_NY, ST_SQ_OX, ST_SQ_OY,
		ST_COMPARE, ST_WRITE, ST_CLEAR, ST_RESULT
	} state_t;

	typedef struct packed {
		logic       cap;
		logic       init;
		logic       cord_step;
		logic       span;
		logic       scale;
		logic       recip;
		logic       idx_bin;
		logic       rd;
		logic       ent_cap;
		logic [1:0] sq_sel;
		logic       sq_en;
		logic       compare;
		logic       write;
		logic       clr_wr;
		logic       mark_zero;
		logic       out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            ring_ok;
		logic            read_ok;
		logic            span_ok;
		logic            cord_last;
		logic            clr_last;
	} ctrl_sts_t;

	// atan(2^-i) in 1/32768 degree, rounded to nearest.
	function automatic logic [ATAN_W-1:0] atan_unit(input logic [4:0] i);
		logic [ATAN_W-1:0] v;
		case (i)
			5'd0:  v = 21'd1474560;
			5'd1:  v = 21'd870484;
			5'd2:  v = 21'd459940;
			5'd3:  v = 21'd233473;
			5'd4:  v = 21'd117189;
			5'd5:  v = 21'd58652;
			5'd6:  v = 21'd29333;
			5'd7:  v = 21'd14667;
			5'd8:  v = 21'd7334;
			5'd9:  v = 21'd3667;
			5'd10: v = 21'd1833;
			5'd11: v = 21'd917;
			5'd12: v = 21'd458;
			5'd13: v = 21'd229;
			5'd14: v = 21'd115;
			5'd15: v = 21'd57;
			5'd16: v = 21'd29;
			5'd17: v = 21'd14;
			5'd18: v = 21'd7;
			5'd19: v = 21'd4;
			5'd20: v = 21'd2;
			5'd21: v = 21'd1;
			default: v = 21'd0;
		endcase
		return v;
	endfunction

endpackage

[src/pbnp_ram.sv]
// Generic single write port, single read port RAM with a registered read.
// Stand-alone; used for the grid store.
module pbnp_ram #(
	parameter int WIDTH = 57,
	parameter int DEPTH = 1440
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/pbnp_ctrl.sv]
// Controller state machine: sequences decode, CORDIC, binning, store access and result.
// Depends on pbnp_pkg for the state type and the command and status structs.
module pbnp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	input  pbnp_pkg::ctrl_sts_t   sts,
	output pbnp_pkg::ctrl_cmd_t   cmd
);

	pbnp_pkg::state_t state_q, state_nx;
	logic             m_valid_q;
	logic             out_free;

	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == pbnp_pkg::ST_IDLE);
	assign m_tvalid = m_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pbnp_pkg::ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			pbnp_pkg::ST_IDLE: begin
				if (s_tvalid) state_nx = pbnp_pkg::ST_DECODE;
			end
			pbnp_pkg::ST_DECODE: begin
				case (sts.op)
					pbnp_pkg::OP_INSERT:
						state_nx = sts.ring_ok ? pbnp_pkg::ST_CORDIC : pbnp_pkg::ST_RESULT;
					pbnp_pkg::OP_READ:
						state_nx = sts.read_ok ? pbnp_pkg::ST_RD_REQ : pbnp_pkg::ST_RESULT;
					pbnp_pkg::OP_CLEAR:
						state_nx = pbnp_pkg::ST_CLEAR;
					default:
						state_nx = pbnp_pkg::ST_RESULT;
				endcase
			end
			pbnp_pkg::ST_CORDIC: begin
				if (sts.cord_last) state_nx = pbnp_pkg::ST_SPAN;
			end
			pbnp_pkg::ST_SPAN:    state_nx = pbnp_pkg::ST_SCALE;
			pbnp_pkg::ST_SCALE:
				state_nx = sts.span_ok ? pbnp_pkg::ST_RECIP : pbnp_pkg::ST_RESULT;
			pbnp_pkg::ST_RECIP:   state_nx = pbnp_pkg::ST_INDEX;
			pbnp_pkg::ST_INDEX:   state_nx = pbnp_pkg::ST_RD_REQ;
			pbnp_pkg::ST_RD_REQ:  state_nx = pbnp_pkg::ST_RD_WAIT;
			pbnp_pkg::ST_RD_WAIT:
				state_nx = (sts.op == pbnp_pkg::OP_READ) ? pbnp_pkg::ST_RESULT
				                                         : pbnp_pkg::ST_SQ_NX;
			pbnp_pkg::ST_SQ_NX:   state_nx = pbnp_pkg::ST_SQ_NY;
			pbnp_pkg::ST_SQ_NY:   state_nx = pbnp_pkg::ST_SQ_OX;
			pbnp_pkg::ST_SQ_OX:   state_nx = pbnp_pkg::ST_SQ_OY;
			pbnp_pkg::ST_SQ_OY:   state_nx = pbnp_pkg::ST_COMPARE;
			pbnp_pkg::ST_COMPARE: state_nx = pbnp_pkg::ST_WRITE;
			pbnp_pkg::ST_WRITE:   state_nx = pbnp_pkg::ST_RESULT;
			pbnp_pkg::ST_CLEAR: begin
				if (sts.clr_last) state_nx = pbnp_pkg::ST_RESULT;
			end
			pbnp_pkg::ST_RESULT: begin
				if (out_free) state_nx = pbnp_pkg::ST_IDLE;
			end
			default: state_nx = pbnp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			pbnp_pkg::ST_IDLE:    cmd.cap = s_tvalid;
			pbnp_pkg::ST_DECODE: begin
				cmd.init = 1'b1;
				case (sts.op)
					pbnp_pkg::OP_INSERT: cmd.mark_zero = !sts.ring_ok;
					pbnp_pkg::OP_READ:   cmd.mark_zero = !sts.read_ok;
					default:             cmd.mark_zero = 1'b1;
				endcase
			end
			pbnp_pkg::ST_CORDIC:  cmd.cord_step = 1'b1;
			pbnp_pkg::ST_SPAN:    cmd.span = 1'b1;
			pbnp_pkg::ST_SCALE: begin
				cmd.scale     = 1'b1;
				cmd.mark_zero = !sts.span_ok;
			end
			pbnp_pkg::ST_RECIP:   cmd.recip = 1'b1;
			pbnp_pkg::ST_INDEX:   cmd.idx_bin = 1'b1;
			pbnp_pkg::ST_RD_REQ:  cmd.rd = 1'b1;
			pbnp_pkg::ST_RD_WAIT: cmd.ent_cap = 1'b1;
			pbnp_pkg::ST_SQ_NX: begin
				cmd.sq_en  = 1'b1;
				cmd.sq_sel = 2'd0;
			end
			pbnp_pkg::ST_SQ_NY: begin
				cmd.sq_en  = 1'b1;
				cmd.sq_sel = 2'd1;
			end
			pbnp_pkg::ST_SQ_OX: begin
				cmd.sq_en  = 1'b1;
				cmd.sq_sel = 2'd2;
			end
			pbnp_pkg::ST_SQ_OY: begin
				cmd.sq_en  = 1'b1;
				cmd.sq_sel = 2'd3;
			end
			pbnp_pkg::ST_COMPARE: cmd.compare = 1'b1;
			pbnp_pkg::ST_WRITE:   cmd.write = 1'b1;
			pbnp_pkg::ST_CLEAR:   cmd.clr_wr = 1'b1;
			pbnp_pkg::ST_RESULT:  cmd.out_load = out_free;
			default:              cmd = '0;
		endcase
	end

endmodule

[src/pbnp_datapath.sv]
// Datapath: origin registers, CORDIC vectoring unit, bin divide, squared distances,
// grid store and the output word. Depends on pbnp_pkg and pbnp_ram.
module pbnp_datapath #(
	parameter int NUM_RINGS    = pbnp_pkg::NUM_RINGS_DEF,
	parameter int NUM_BINS     = pbnp_pkg::NUM_BINS_DEF,
	parameter int CORDIC_STEPS = pbnp_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [pbnp_pkg::IN_DATA_W-1:0]       s_tdata,
	input  logic [pbnp_pkg::OP_W-1:0]            s_tuser,
	input  logic                                 cfg_valid,
	input  logic [pbnp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pbnp_pkg::COORD_W-1:0]         cfg_data,
	output logic [pbnp_pkg::OUT_DATA_W-1:0]      m_tdata,
	input  pbnp_pkg::ctrl_cmd_t                  cmd,
	output pbnp_pkg::ctrl_sts_t                  sts
);

	localparam int DEPTH = NUM_RINGS * NUM_BINS;
	localparam int IW    = $clog2(DEPTH);
	localparam int BW    = $clog2(NUM_BINS);
	localparam int CW    = pbnp_pkg::DELTA_W + CORDIC_STEPS + 3;
	localparam int CNT_W = $clog2(CORDIC_STEPS);
	localparam int PW    = pbnp_pkg::TVAL_W + $clog2(NUM_BINS + 1);
	localparam int EW    = pbnp_pkg::QUO_W + pbnp_pkg::RECIP_W;
	localparam int CD    = pbnp_pkg::COORD_W;
	localparam int DW    = pbnp_pkg::DELTA_W;
	localparam int AW    = pbnp_pkg::ANGLE_W;

	logic signed [CD-1:0] orx_q, ory_q, orz_q;
	logic [pbnp_pkg::OP_W-1:0]   op_q;
	logic [pbnp_pkg::RING_W-1:0] ring_q;
	logic [pbnp_pkg::BIN_W-1:0]  rbin_q;
	logic signed [CD-1:0] px_q, py_q, pz_q;
	logic                 zero_q;

	logic signed [DW-1:0] dx_c, dy_c, dx_q, dy_q;
	logic signed [CW-1:0] cx_q, cy_q, xs, ys;
	logic signed [AW-1:0] z_q, zsum;
	logic [CNT_W-1:0]     cnt_q;

	logic [pbnp_pkg::TVAL_W-1:0] t_q;
	logic                        span_ok_q;
	logic [PW-1:0]               p_q;
	logic [pbnp_pkg::QUO_W-1:0]  quo;
	logic [EW-1:0]               est;
	logic [BW-1:0]               bin_q;
	logic [IW-1:0]               addr_q, clr_q;

	logic [pbnp_pkg::ENTRY_W-1:0] rdata, ent_q, wdata;
	logic                         we;
	logic [IW-1:0]                waddr;
	logic signed [CD-1:0]         ent_x, ent_y;
	logic signed [DW-1:0]         ox_c, oy_c, sq_op;
	logic signed [2*DW-1:0]       sq_prod;
	logic [pbnp_pkg::SQ_W-1:0]    sq_q [4];
	logic [pbnp_pkg::DIST_W-1:0]  dnew, dold;
	logic                         repl_q;
	logic [pbnp_pkg::OUT_DATA_W-1:0] out_q;

	assign dx_c = $signed({px_q[CD-1], px_q}) - $signed({orx_q[CD-1], orx_q});
	assign dy_c = $signed({py_q[CD-1], py_q}) - $signed({ory_q[CD-1], ory_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orx_q <= '0;
			ory_q <= '0;
			orz_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				pbnp_pkg::CFG_ORIGIN_X: orx_q <= cfg_data;
				pbnp_pkg::CFG_ORIGIN_Y: ory_q <= cfg_data;
				pbnp_pkg::CFG_ORIGIN_Z: orz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		xs   = cx_q >>> cnt_q;
		ys   = cy_q >>> cnt_q;
		zsum = z_q + AW'(pbnp_pkg::HALF_SPAN);
	end

	// Input capture, CORDIC iterations and the bin computation.
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q   <= s_tuser;
			ring_q <= s_tdata[3:0];
			rbin_q <= s_tdata[10:4];
			px_q   <= s_tdata[29:11];
			py_q   <= s_tdata[48:30];
			pz_q   <= s_tdata[67:49];
			zero_q <= 1'b0;
		end
		if (cmd.mark_zero) zero_q <= 1'b1;
		if (cmd.init) begin
			dx_q   <= dx_c;
			dy_q   <= dy_c;
			cx_q   <= {{3{dx_c[DW-1]}}, dx_c, {CORDIC_STEPS{1'b0}}};
			cy_q   <= {{3{dy_c[DW-1]}}, dy_c, {CORDIC_STEPS{1'b0}}};
			z_q    <= '0;
			cnt_q  <= '0;
			clr_q  <= '0;
			addr_q <= IW'(ring_q) * IW'(NUM_BINS) + IW'(rbin_q);
		end
		if (cmd.cord_step) begin
			cnt_q <= cnt_q + 1'b1;
			if (!cy_q[CW-1]) begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				z_q  <= z_q + $signed(AW'(pbnp_pkg::atan_unit(5'(cnt_q))));
			end else begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				z_q  <= z_q - $signed(AW'(pbnp_pkg::atan_unit(5'(cnt_q))));
			end
		end
		if (cmd.span) begin
			// A point straight left or right of the sensor skips the CORDIC result.
			if (dx_q == '0) begin
				span_ok_q <= !(dy_q > 0);
				t_q <= (dy_q < 0) ? '0 : pbnp_pkg::TVAL_W'(pbnp_pkg::HALF_SPAN);
			end else begin
				span_ok_q <= !dx_q[DW-1] && (zsum >= 0) && (zsum < pbnp_pkg::FULL_SPAN);
				t_q       <= zsum[pbnp_pkg::TVAL_W-1:0];
			end
		end
		if (cmd.scale) p_q <= PW'(t_q) * PW'(NUM_BINS);
		// The reciprocal estimate is exact for every quotient below 45 * 1024.
		if (cmd.recip) bin_q <= BW'(est >> pbnp_pkg::RECIP_SHIFT);
		if (cmd.idx_bin) addr_q <= IW'(ring_q) * IW'(NUM_BINS) + IW'(bin_q);
		if (cmd.clr_wr) clr_q <= clr_q + 1'b1;
		if (cmd.ent_cap) ent_q <= rdata;
		if (cmd.sq_en) sq_q[cmd.sq_sel] <= pbnp_pkg::SQ_W'(sq_prod);
		if (cmd.compare) repl_q <= (dnew < dold) || (dold == '0);
	end

	assign quo = pbnp_pkg::QUO_W'(p_q >> pbnp_pkg::SPAN_SHIFT);
	assign est = EW'(quo) * EW'(pbnp_pkg::RECIP);

	assign ent_x = ent_q[CD-1:0];
	assign ent_y = ent_q[2*CD-1:CD];
	assign ox_c  = $signed({ent_x[CD-1], ent_x}) - $signed({orx_q[CD-1], orx_q});
	assign oy_c  = $signed({ent_y[CD-1], ent_y}) - $signed({ory_q[CD-1], ory_q});

	always_comb begin
		case (cmd.sq_sel)
			2'd0:    sq_op = dx_q;
			2'd1:    sq_op = dy_q;
			2'd2:    sq_op = ox_c;
			default: sq_op = oy_c;
		endcase
		sq_prod = sq_op * sq_op;
		dnew = {1'b0, sq_q[0]} + {1'b0, sq_q[1]};
		dold = {1'b0, sq_q[2]} + {1'b0, sq_q[3]};
	end

	always_comb begin
		we    = (cmd.write && repl_q) || cmd.clr_wr;
		waddr = cmd.clr_wr ? clr_q : addr_q;
		wdata = cmd.clr_wr ? {orz_q, ory_q, orx_q} : {pz_q, py_q, px_q};
	end

	pbnp_ram #(
		.WIDTH (pbnp_pkg::ENTRY_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.rd),
		.raddr (addr_q),
		.rdata (rdata)
	);

	// Result word packing; skipped and cleared words read as all zero.
	function automatic logic [pbnp_pkg::OUT_DATA_W-1:0] pack_out(
		input logic                         zero,
		input logic [pbnp_pkg::OP_W-1:0]    op,
		input logic [pbnp_pkg::ENTRY_W-1:0] ent,
		input logic [pbnp_pkg::ENTRY_W-1:0] pnt,
		input logic [pbnp_pkg::BIN_W-1:0]   rbin,
		input logic [pbnp_pkg::BIN_W-1:0]   cbin,
		input logic                         repl
	);
		logic [pbnp_pkg::OUT_DATA_W-1:0] w;
		w = '0;
		if (!zero) begin
			if (op == pbnp_pkg::OP_READ) begin
				w[56:0]  = ent;
				w[63:57] = rbin;
			end else begin
				w[56:0]  = repl ? pnt : ent;
				w[63:57] = cbin;
				w[64]    = 1'b1;
				w[65]    = repl;
			end
		end
		return w;
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= pack_out(zero_q, op_q, ent_q, {pz_q, py_q, px_q}, rbin_q,
			                  pbnp_pkg::BIN_W'(bin_q), repl_q);
		end
	end

	assign m_tdata = out_q;

	always_comb begin
		sts.op        = op_q;
		sts.ring_ok   = 32'(ring_q) < NUM_RINGS;
		sts.read_ok   = (32'(ring_q) < NUM_RINGS) && (32'(rbin_q) < NUM_BINS);
		sts.span_ok   = span_ok_q;
		sts.cord_last = (32'(cnt_q) == CORDIC_STEPS - 1);
		sts.clr_last  = (32'(clr_q) == DEPTH - 1);
	end

endmodule

[src/polar_bin_nearest_point_core.sv]
// Polar bin nearest point core: for every (ring, angle bin) keeps the lidar point nearest
// to the sensor origin in the horizontal plane.
// Channels: s_* carries one op word in, m_* carries one result word out, cfg_* writes
//   origin_x (index 0), origin_y (index 1), origin_z (index 2). cfg_ready is always high;
//   write the origin only while the core is idle.
// Ops in s_tuser: insert a point, read one entry, clear all entries to the origin.
// The store powers up undefined and must be cleared once before its first use.
// Inserts go through the serial CORDIC unit and the single shared squaring multiplier;
//   a clear writes one store row per cycle through the single write port.
// One word is in work at a time; s_tready is high only while the core is idle.
// The result sits in an output register; the core takes the next word while it waits.
// When m_tready is low the result holds and the core stops before loading the next one.
// Reset clears the origin registers and the handshake state; the store is left as is.
module polar_bin_nearest_point_core #(
	parameter int NUM_RINGS    = pbnp_pkg::NUM_RINGS_DEF,
	parameter int NUM_BINS     = pbnp_pkg::NUM_BINS_DEF,
	parameter int CORDIC_STEPS = pbnp_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// ring[3:0], bin[10:4], point_x[29:11], point_y[48:30], point_z[67:49], zero pad
	input  logic [pbnp_pkg::IN_DATA_W-1:0]       s_tdata,
	// op[1:0]
	input  logic [pbnp_pkg::OP_W-1:0]            s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// entry_x[18:0], entry_y[37:19], entry_z[56:38], bin_used[63:57], in_range[64],
	// replaced[65], zero pad
	output logic [pbnp_pkg::OUT_DATA_W-1:0]      m_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pbnp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pbnp_pkg::COORD_W-1:0]         cfg_data
);

	pbnp_pkg::ctrl_cmd_t cmd;
	pbnp_pkg::ctrl_sts_t sts;

	assign cfg_ready = 1'b1;

	pbnp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pbnp_datapath #(
		.NUM_RINGS    (NUM_RINGS),
		.NUM_BINS     (NUM_BINS),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

[src/pbnp_checker.sv]
// Port-level checker for the polar bin nearest point core, bound to the top level.
// Depends on pbnp_pkg for port widths.
module pbnp_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [pbnp_pkg::OUT_DATA_W-1:0] m_tdata
);

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// Only an insert that landed in the span can replace an entry.
	a_repl_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[65] && !m_tdata[64]))
		else $error("replaced set without in_range");

	// One word at a time: after an accept the core is busy on the next cycle.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("word accepted while another is in work");

	// Nothing above the defined result fields is ever set.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[71:66] == 6'd0))
		else $error("pad bits of result word set");

endmodule

bind polar_bin_nearest_point_core pbnp_checker u_pbnp_checker (.*);
